// File: hdl/pcte_pkg.sv
// shared types, constants and per-byte extraction functions
package pcte_pkg;

    localparam int MAXRES = 8;
    localparam int CNT_W  = $clog2(MAXRES + 1);
    localparam int IDX_W  = $clog2(MAXRES);

    typedef logic [7:0] t_byte;

    localparam t_byte WRAP_RESET = 8'd70;

    localparam t_byte C_B     = 8'h42;
    localparam t_byte C_E     = 8'h45;
    localparam t_byte C_T     = 8'h54;
    localparam t_byte C_LP    = 8'h28;
    localparam t_byte C_RP    = 8'h29;
    localparam t_byte C_LT    = 8'h3C;
    localparam t_byte C_BSL   = 8'h5C;
    localparam t_byte C_SPACE = 8'h20;
    localparam t_byte C_TAB   = 8'h09;
    localparam t_byte C_LF    = 8'h0A;
    localparam t_byte C_CR    = 8'h0D;
    localparam t_byte C_BS    = 8'h08;
    localparam t_byte C_FF    = 8'h0C;
    localparam t_byte C_ESC_N = 8'h6E;
    localparam t_byte C_ESC_R = 8'h72;
    localparam t_byte C_ESC_T = 8'h74;
    localparam t_byte C_ESC_B = 8'h62;
    localparam t_byte C_ESC_F = 8'h66;

    localparam logic [1:0] OP_IDLE   = 2'd0;
    localparam logic [1:0] OP_LETTER = 2'd1;
    localparam logic [1:0] OP_PAIR   = 2'd2;

    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_BSL  = 2'd1;
    localparam logic [1:0] ESC_OCT1 = 2'd2;
    localparam logic [1:0] ESC_OCT2 = 2'd3;

    typedef struct packed {
        logic        in_text;
        logic        at_ws;
        logic [7:0]  depth;
        logic [15:0] col;
        logic [1:0]  op;
        logic [1:0]  esc;
        logic [5:0]  oct_hold;
        logic        hex_mode;
        logic        hex_nv;
        logic [3:0]  hex_nib;
        logic        buf_ended;
    } t_state;

    localparam t_state ST_RESET = '{
        in_text: 1'b0, at_ws: 1'b1, depth: 8'd0, col: 16'd0, op: OP_IDLE,
        esc: ESC_IDLE, oct_hold: 6'd0, hex_mode: 1'b0, hex_nv: 1'b0,
        hex_nib: 4'd0, buf_ended: 1'b0};

    typedef struct packed {
        t_byte      data_byte;
        logic       is_last;
    } t_item;

    typedef struct packed {
        t_byte [MAXRES-1:0] bytes;
        logic  [CNT_W-1:0]  cnt;
    } t_res;

    typedef struct packed {
        t_state st;
        t_res   res;
    } t_ctx;

    function automatic t_ctx f_emit(input t_ctx x, input t_byte b);
        if (b != 8'h00 && x.res.cnt < CNT_W'(MAXRES)) begin
            x.res.bytes[x.res.cnt[IDX_W-1:0]] = b;
            x.res.cnt = x.res.cnt + 1'b1;
        end
        return x;
    endfunction

    function automatic logic f_is_ws(input t_byte c);
        return c == C_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic f_is_hex(input t_byte c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] f_hex_val(input t_byte c);
        t_byte d;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

    function automatic t_byte f_digit(input logic [2:0] v);
        return {5'b00110, v};
    endfunction

    function automatic t_ctx f_col_inc(input t_ctx x);
        if (x.st.col != 16'hFFFF) begin
            x.st.col = x.st.col + 16'd1;
        end
        return x;
    endfunction

    function automatic t_ctx f_string_char(input t_ctx x, input t_byte c, input t_byte wrap);
        x = f_emit(x, c);
        if (c == C_CR || c == C_LF) begin
            x.st.col = 16'd0;
        end else begin
            x = f_col_inc(x);
        end
        if ({8'h00, wrap} < x.st.col && (c == C_SPACE || c == C_TAB)) begin
            x = f_emit(x, C_LF);
            x.st.col = 16'd0;
        end
        return x;
    endfunction

    function automatic t_ctx f_plain(input t_ctx x, input t_byte c, input t_byte wrap);
        logic pos;
        pos = !x.st.depth[7] && x.st.depth != 8'h00;
        if (pos && c == C_BSL) begin
            x.st.esc = ESC_BSL;
        end else if (c == C_LP) begin
            if (x.st.depth != 8'h7F) begin
                x.st.depth = x.st.depth + 8'd1;
            end
        end else if (c == C_RP) begin
            if (x.st.depth != 8'h80) begin
                x.st.depth = x.st.depth - 8'd1;
            end
        end else if (pos) begin
            x = f_string_char(x, c, wrap);
        end else if (c == C_LT) begin
            x.st.hex_mode = 1'b1;
            x.st.hex_nv   = 1'b0;
        end
        return x;
    endfunction

    function automatic t_ctx f_normal(input t_ctx x, input t_byte c, input t_byte wrap);
        logic ws;
        ws = f_is_ws(c);
        if (!x.st.in_text) begin
            if (x.st.at_ws && c == C_B) begin
                x.st.op = OP_LETTER;
            end else begin
                x.st.at_ws = ws;
            end
        end else if (x.st.at_ws && c == C_E) begin
            x.st.op = OP_LETTER;
        end else if (!(ws && x.st.at_ws)) begin
            x.st.at_ws = ws;
            x = f_plain(x, c, wrap);
        end
        return x;
    endfunction

    function automatic t_ctx f_letter_flush(input t_ctx x, input t_byte c, input t_byte wrap);
        x.st.at_ws = 1'b0;
        if (x.st.in_text) begin
            x = f_plain(x, c, wrap);
        end
        return x;
    endfunction

    function automatic t_ctx f_flush(input t_ctx x, input t_byte wrap);
        t_byte      letter;
        logic [1:0] ph;
        letter = x.st.in_text ? C_E : C_B;
        ph     = x.st.op;
        if (ph != OP_IDLE) begin
            x.st.op = OP_IDLE;
            x = f_letter_flush(x, letter, wrap);
            if (ph == OP_PAIR) begin
                x = f_letter_flush(x, C_T, wrap);
            end
        end
        if (x.st.esc == ESC_OCT1) begin
            x = f_emit(x, f_digit(x.st.oct_hold[2:0]));
        end else if (x.st.esc == ESC_OCT2) begin
            x.st.esc = ESC_IDLE;
            x = f_emit(x, f_digit(x.st.oct_hold[5:3]));
            x = f_normal(x, f_digit(x.st.oct_hold[2:0]), wrap);
        end
        x = f_emit(x, C_SPACE);
        x.st.in_text  = 1'b0;
        x.st.at_ws    = 1'b1;
        x.st.depth    = 8'd0;
        x.st.op       = OP_IDLE;
        x.st.esc      = ESC_IDLE;
        x.st.oct_hold = 6'd0;
        x.st.hex_mode = 1'b0;
        x.st.hex_nv   = 1'b0;
        x.st.hex_nib  = 4'd0;
        return x;
    endfunction

    function automatic t_ctx f_take(input t_ctx x, input t_byte c, input t_byte wrap);
        logic  oct;
        logic  hx;
        t_byte letter;
        t_byte esc_val;
        oct    = c >= 8'h30 && c <= 8'h37;
        hx     = f_is_hex(c);
        letter = x.st.in_text ? C_E : C_B;
        case (c)
            C_ESC_N: esc_val = C_LF;
            C_ESC_R: esc_val = C_CR;
            C_ESC_T: esc_val = C_TAB;
            C_ESC_B: esc_val = C_BS;
            C_ESC_F: esc_val = C_FF;
            default: esc_val = c;
        endcase
        if (x.st.hex_mode) begin
            if (!x.st.hex_nv) begin
                if (hx) begin
                    x.st.hex_nib = f_hex_val(c);
                    x.st.hex_nv  = 1'b1;
                end else begin
                    x.st.hex_mode = 1'b0;
                end
            end else begin
                x.st.hex_nv = 1'b0;
                if (hx) begin
                    x = f_emit(x, {x.st.hex_nib, f_hex_val(c)});
                    x = f_col_inc(x);
                end else begin
                    x.st.hex_mode = 1'b0;
                    x = f_normal(x, c, wrap);
                end
            end
        end else if (x.st.esc == ESC_BSL) begin
            x.st.esc = ESC_IDLE;
            if (oct) begin
                x.st.oct_hold = {3'b000, c[2:0]};
                x.st.esc      = ESC_OCT1;
            end else begin
                x = f_emit(x, esc_val);
            end
        end else if (x.st.esc == ESC_OCT1) begin
            if (oct) begin
                x.st.oct_hold = {x.st.oct_hold[2:0], c[2:0]};
                x.st.esc      = ESC_OCT2;
            end else begin
                x.st.esc = ESC_IDLE;
                x = f_emit(x, f_digit(x.st.oct_hold[2:0]));
                x = f_normal(x, c, wrap);
            end
        end else if (x.st.esc == ESC_OCT2) begin
            x.st.esc = ESC_IDLE;
            if (oct) begin
                x = f_emit(x, {x.st.oct_hold[4:0], c[2:0]});
            end else begin
                x = f_emit(x, f_digit(x.st.oct_hold[5:3]));
                x = f_normal(x, f_digit(x.st.oct_hold[2:0]), wrap);
                x = f_normal(x, c, wrap);
            end
        end else if (x.st.op == OP_LETTER) begin
            if (c == C_T) begin
                x.st.op = OP_PAIR;
            end else begin
                x.st.op = OP_IDLE;
                x = f_letter_flush(x, letter, wrap);
                x = f_normal(x, c, wrap);
            end
        end else if (x.st.op == OP_PAIR) begin
            x.st.op = OP_IDLE;
            if (f_is_ws(c)) begin
                x.st.in_text = !x.st.in_text;
                x.st.at_ws   = 1'b1;
            end else begin
                x = f_letter_flush(x, letter, wrap);
                x = f_letter_flush(x, C_T, wrap);
                x = f_normal(x, c, wrap);
            end
        end else begin
            x = f_normal(x, c, wrap);
        end
        return x;
    endfunction

    function automatic t_ctx f_step(input t_state st, input t_item it, input t_byte wrap);
        t_ctx x;
        x.st  = st;
        x.res = '0;
        if (st.buf_ended) begin
            if (it.is_last) begin
                x.st.buf_ended = 1'b0;
            end
        end else if (it.data_byte == 8'h00) begin
            x = f_flush(x, wrap);
            if (!it.is_last) begin
                x.st.buf_ended = 1'b1;
            end
        end else begin
            x = f_take(x, it.data_byte, wrap);
            if (it.is_last) begin
                x = f_flush(x, wrap);
            end
        end
        return x;
    endfunction

endpackage

// File: hdl/pcte_if.sv
// stream and configuration channel interfaces
interface pcte_in_if import pcte_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  is_last;
    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface pcte_out_if import pcte_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte text_byte;
    logic  last_of_run;
    modport source (output valid, output text_byte, output last_of_run, input ready);
    modport sink (input valid, input text_byte, input last_of_run, output ready);
endinterface

interface pcte_cfg_if import pcte_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte wrap_column;
    modport source (output valid, output wrap_column, input ready);
    modport sink (input valid, input wrap_column, output ready);
endinterface

// File: hdl/pcte_in_reg.sv
// input register stage for stream bytes
module pcte_in_reg import pcte_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pcte_in_if.sink      i_in,
    input  logic         i_take,
    output logic         o_valid,
    output t_item        o_item
);
    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_load;

    assign i_in.ready = !r_valid || i_take;
    assign w_load     = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= '{data_byte: i_in.data_byte, is_last: i_in.is_last};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// File: hdl/pcte_core.sv
// parser state and single-pass byte processing
module pcte_core import pcte_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_item  i_item,
    input  t_byte  i_wrap,
    input  logic   i_free,
    output logic   o_fire,
    output t_res   o_res
);
    t_state r_state;
    t_state n_state;
    t_ctx   w_ctx;

    assign o_fire = i_valid && i_free;

    always_comb begin
        w_ctx   = f_step(r_state, i_item, i_wrap);
        n_state = o_fire ? w_ctx.st : r_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_res = w_ctx.res;
endmodule

// File: hdl/pcte_res.sv
// result register, drains one text byte per beat
module pcte_res import pcte_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_res         i_res,
    pcte_out_if.source   o_out,
    output logic         o_free
);
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    t_byte [MAXRES-1:0] r_bytes;
    logic               w_is_last;
    logic               w_beat;

    assign w_is_last         = {1'b0, r_idx} == r_cnt - 1'b1;
    assign o_out.valid       = r_cnt != '0;
    assign o_out.text_byte   = r_bytes[r_idx];
    assign o_out.last_of_run = w_is_last;
    assign w_beat            = o_out.valid && o_out.ready;
    assign o_free            = r_cnt == '0 || (w_beat && w_is_last);

    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (i_load) begin
            n_cnt = i_res.cnt;
            n_idx = '0;
        end else if (w_beat) begin
            if (w_is_last) begin
                n_cnt = '0;
                n_idx = '0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_res.bytes;
        end
    end
endmodule

// File: hdl/pdf_content_text_extractor.sv
// top level: text extraction from decoded content stream bytes
// flow: input register, core logic, then result register to the output
// throughput: one byte per cycle while each byte yields at most one text byte
//   and o_out is ready; more text bytes hold the result register till sent
// reset: synchronous active low, parser state to idle, wrap column to 70
module pdf_content_text_extractor import pcte_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcte_in_if.sink       i_in,
    pcte_out_if.source    o_out,
    pcte_cfg_if.sink      i_cfg
);
    t_byte r_wrap_column;
    logic  w_in_valid;
    t_item w_item;
    logic  w_fire;
    logic  w_free;
    t_res  w_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_column <= WRAP_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_wrap_column <= i_cfg.wrap_column;
        end
    end

    pcte_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_item  (w_item)
    );

    pcte_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_in_valid),
        .i_item  (w_item),
        .i_wrap  (r_wrap_column),
        .i_free  (w_free),
        .o_fire  (w_fire),
        .o_res   (w_res)
    );

    pcte_res u_res (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_res   (w_res),
        .o_out   (o_out),
        .o_free  (w_free)
    );

    a_no_zero_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.text_byte != 8'h00)
        else $error("zero text byte presented");

    a_idle_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out.valid)
        else $error("output valid right after reset");

    a_stall_only_on_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_valid && !w_fire |-> o_out.valid)
        else $error("held byte stalled with no results pending");
endmodule
